@@ rtl/dpb_pkg.sv @@
// Shared types, constants and width helpers for the depth pixel back-projection block.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package dpb_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam int DEPTH_W   = 16;
    localparam int FOCAL_W   = 24;
    localparam int FOCAL_LO  = 12;
    localparam int CENTER_W  = 16;
    localparam int COEF_W    = 16;
    localparam int ROW_W     = 4 * COEF_W;
    localparam int COLOUR_W  = 32;
    localparam int WORLD_W   = 32;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 64;

    // Intrinsics rounding: Q.40 product down to Q.16
    localparam int CAM_SHIFT = 24;
    // Transform rounding: Q.28 sum down to Q.16
    localparam int MAT_SHIFT = 12;
    // cam_z = depth * 16, held as a non-negative signed value
    localparam int CAMZ_W    = DEPTH_W + 5;
    localparam int PZ_W      = CAMZ_W + COEF_W;
    // cam_w = 1.0 in Q16.16
    localparam int ONE_SHIFT = 16;

    localparam logic [FOCAL_W-1:0]  INV_FX_RST = 24'd31960;
    localparam logic [FOCAL_W-1:0]  INV_FY_RST = 24'd31960;
    localparam logic [CENTER_W-1:0] CX_RST     = 16'd5120;
    localparam logic [CENTER_W-1:0] CY_RST     = 16'd3840;
    localparam logic [ROW_W-1:0]    ROW0_RST   = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0]    ROW1_RST   = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0]    ROW2_RST   = 64'h0000_1000_0000_0000;
    localparam logic [ROW_W-1:0]    ROW3_RST   = 64'h1000_0000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_FX = 4'd0,
        REG_INV_FY = 4'd1,
        REG_CX     = 4'd2,
        REG_CY     = 4'd3,
        REG_ROW0   = 4'd4,
        REG_ROW1   = 4'd5,
        REG_ROW2   = 4'd6,
        REG_ROW3   = 4'd7
    } cfg_reg_t;

    // Stage advance strobes for the intrinsics lane
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } axis_en_t;

    // Signed width of column*16 - center
    function automatic int dx_width(input int coord_bits);
        int cw;
        begin
            cw = coord_bits + 4;
            dx_width = ((cw > CENTER_W) ? cw : CENTER_W) + 1;
        end
    endfunction

    // Signed width of (column*16 - center) * depth
    function automatic int pd_width(input int coord_bits);
        pd_width = dx_width(coord_bits) + DEPTH_W;
    endfunction

    // Signed width of a camera coordinate after rounding
    function automatic int cam_width(input int coord_bits);
        cam_width = pd_width(coord_bits) + 1;
    endfunction

endpackage

@@ rtl/dpb_if.sv @@
// Channel interfaces: depth pixel input, world point output, register writes.
// Depends on dpb_pkg for field widths.
interface dpb_pixel_if #(
    parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [dpb_pkg::DEPTH_W-1:0]   depth;
    logic                          depth_valid;
    logic [COORD_BITS-1:0]         column;
    logic [COORD_BITS-1:0]         row;
    logic [dpb_pkg::COLOUR_W-1:0]  rgbx;

    modport source (output valid, depth, depth_valid, column, row, rgbx, input ready);
    modport sink   (input valid, depth, depth_valid, column, row, rgbx, output ready);
endinterface

interface dpb_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [dpb_pkg::WORLD_W-1:0]  world_x;
    logic signed [dpb_pkg::WORLD_W-1:0]  world_y;
    logic signed [dpb_pkg::WORLD_W-1:0]  world_z;
    logic signed [dpb_pkg::WORLD_W-1:0]  world_w;
    logic [dpb_pkg::COLOUR_W-1:0]        point_colour;
    logic                                point_valid;

    modport source (output valid, world_x, world_y, world_z, world_w, point_colour,
                    point_valid, input ready);
    modport sink   (input valid, world_x, world_y, world_z, world_w, point_colour,
                    point_valid, output ready);
endinterface

interface dpb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dpb_pkg::CFG_IDX_W-1:0]  index;
    logic [dpb_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/dpb_axis.sv @@
// One intrinsics lane: (coord*16 - center) * depth * inv_focal, rounded to Q.16.
// Four register stages; depends on dpb_pkg.
module dpb_axis #(
    parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF
) (
    input  logic                                           clk,
    input  dpb_pkg::axis_en_t                              en,
    input  logic [COORD_BITS-1:0]                          coord,
    input  logic [dpb_pkg::CENTER_W-1:0]                   center,
    input  logic [dpb_pkg::DEPTH_W-1:0]                    depth,
    input  logic [dpb_pkg::FOCAL_W-1:0]                    inv_focal,
    output logic signed [dpb_pkg::cam_width(COORD_BITS)-1:0] cam
);
    localparam int DX_W  = dpb_pkg::dx_width(COORD_BITS);
    localparam int PD_W  = dpb_pkg::pd_width(COORD_BITS);
    localparam int CAM_W = dpb_pkg::cam_width(COORD_BITS);
    localparam int FHI_W = dpb_pkg::FOCAL_W - dpb_pkg::FOCAL_LO;
    localparam int PL_W  = PD_W + dpb_pkg::FOCAL_LO;
    localparam int PH_W  = PD_W + FHI_W;
    localparam int SUM_W = PD_W + dpb_pkg::FOCAL_W + 1;

    logic signed [DX_W-1:0]             dx_next;
    logic signed [DX_W-1:0]             dx_reg;
    logic [dpb_pkg::DEPTH_W-1:0]        depth_reg;
    logic signed [PD_W-1:0]             pd_next;
    logic signed [PD_W-1:0]             pd_reg;
    logic signed [PL_W-1:0]             pl_next;
    logic signed [PH_W-1:0]             ph_next;
    logic signed [PL_W-1:0]             pl_reg;
    logic signed [PH_W-1:0]             ph_reg;
    logic signed [SUM_W-1:0]            sum;
    logic signed [CAM_W-1:0]            cam_next;
    logic signed [CAM_W-1:0]            cam_reg;

    // Stage 1: offset from the principal point, Q.4
    assign dx_next = $signed(DX_W'({coord, 4'b0000})) - $signed(DX_W'(center));

    // Stage 2: scale by depth
    assign pd_next = dx_reg * $signed({1'b0, depth_reg});

    // Stage 3: split the reciprocal focal length into two narrow products
    assign pl_next = pd_reg * $signed({1'b0, inv_focal[dpb_pkg::FOCAL_LO-1:0]});
    assign ph_next = pd_reg *
                     $signed({1'b0, inv_focal[dpb_pkg::FOCAL_W-1:dpb_pkg::FOCAL_LO]});

    // Stage 4: recombine, round half up, drop 24 fraction bits
    assign sum = (SUM_W'(ph_reg) <<< dpb_pkg::FOCAL_LO) + SUM_W'(pl_reg)
               + (SUM_W'(1) <<< (dpb_pkg::CAM_SHIFT - 1));
    assign cam_next = sum[SUM_W-1:dpb_pkg::CAM_SHIFT];

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            dx_reg    <= dx_next;
            depth_reg <= depth;
        end
        if (en.s2)
        begin
            pd_reg <= pd_next;
        end
        if (en.s3)
        begin
            pl_reg <= pl_next;
            ph_reg <= ph_next;
        end
        if (en.s4)
        begin
            cam_reg <= cam_next;
        end
    end

    assign cam = cam_reg;

endmodule

@@ rtl/depth_pixel_backprojection.sv @@
// Top level: pinhole back-projection of depth pixels into world space.
// Depends on dpb_pkg, the interfaces in dpb_if.sv and dpb_axis.
//
//  channel | modport | handshake   | payload
//  --------+---------+-------------+-----------------------------------------------
//  pixel   | sink    | valid/ready | depth, depth_valid, column, row, rgbx
//  point   | source  | valid/ready | world_x/y/z/w, point_colour, point_valid
//  cfg     | sink    | valid/ready | index, data (ready is always high)
//
// One transaction enters per cycle unless a stalled output backs the pipe up.
// The seven stages are: offset, depth product, split focal products, round to
// camera space, transform products, row sums, round and saturate (output register).
// Each stage holds only when it is full and the stage after it holds, so a stalled
// output fills bubbles before pixel.ready drops. Reset clears the valid bits and
// loads the intrinsics and identity transform; the data path carries no reset.
module depth_pixel_backprojection #(
    parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dpb_pixel_if.sink  pixel,
    dpb_point_if.source point,
    dpb_cfg_if.sink    cfg
);
    localparam int NSTAGE = 7;
    localparam int CAM_W  = dpb_pkg::cam_width(COORD_BITS);
    localparam int PXY_W  = CAM_W + dpb_pkg::COEF_W;
    localparam int ACC_W  = PXY_W + 2;
    localparam int RND_W  = ACC_W + 1;
    localparam int SH_W   = RND_W - dpb_pkg::MAT_SHIFT;

    // Data that rides alongside the arithmetic
    typedef struct packed {
        logic [dpb_pkg::DEPTH_W-1:0]  depth;
        logic                         flag;
        logic [dpb_pkg::COLOUR_W-1:0] colour;
    } side_t;

    // ---------------- configuration registers ----------------
    logic [dpb_pkg::FOCAL_W-1:0]     inv_fx_reg;
    logic [dpb_pkg::FOCAL_W-1:0]     inv_fy_reg;
    logic [dpb_pkg::CENTER_W-1:0]    cx_reg;
    logic [dpb_pkg::CENTER_W-1:0]    cy_reg;
    logic [3:0][dpb_pkg::ROW_W-1:0]  mat_reg;

    assign cfg.ready = 1'b1;

    // Writes to indexes past the list fall into the default arm and are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_fx_reg <= dpb_pkg::INV_FX_RST;
            inv_fy_reg <= dpb_pkg::INV_FY_RST;
            cx_reg     <= dpb_pkg::CX_RST;
            cy_reg     <= dpb_pkg::CY_RST;
            mat_reg[0] <= dpb_pkg::ROW0_RST;
            mat_reg[1] <= dpb_pkg::ROW1_RST;
            mat_reg[2] <= dpb_pkg::ROW2_RST;
            mat_reg[3] <= dpb_pkg::ROW3_RST;
        end
        else if (cfg.valid)
        begin
            case (dpb_pkg::cfg_reg_t'(cfg.index))
                dpb_pkg::REG_INV_FX: inv_fx_reg <= cfg.data[dpb_pkg::FOCAL_W-1:0];
                dpb_pkg::REG_INV_FY: inv_fy_reg <= cfg.data[dpb_pkg::FOCAL_W-1:0];
                dpb_pkg::REG_CX:     cx_reg     <= cfg.data[dpb_pkg::CENTER_W-1:0];
                dpb_pkg::REG_CY:     cy_reg     <= cfg.data[dpb_pkg::CENTER_W-1:0];
                dpb_pkg::REG_ROW0:   mat_reg[0] <= cfg.data;
                dpb_pkg::REG_ROW1:   mat_reg[1] <= cfg.data;
                dpb_pkg::REG_ROW2:   mat_reg[2] <= cfg.data;
                dpb_pkg::REG_ROW3:   mat_reg[3] <= cfg.data;
                default: ;
            endcase
        end
    end

    // Coefficient (r, c) is bits [16c+15:16c] of row r
    logic signed [dpb_pkg::COEF_W-1:0] coef [4][4];

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                coef[r][c] = $signed(mat_reg[r][c*dpb_pkg::COEF_W +: dpb_pkg::COEF_W]);
            end
        end
    end

    // ---------------- pipeline control ----------------
    logic [NSTAGE:1] v_reg;
    logic [NSTAGE:1] en;

    // A stage advances when it is empty or the next one advances
    always_comb
    begin
        en[NSTAGE] = !v_reg[NSTAGE] || point.ready;
        for (int k = NSTAGE - 1; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign pixel.ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= pixel.valid;
            end
            for (int k = 2; k <= NSTAGE; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // ---------------- side band ----------------
    side_t side_reg [1:NSTAGE-1];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            side_reg[1] <= '{depth: pixel.depth, flag: pixel.depth_valid, colour: pixel.rgbx};
        end
        for (int k = 2; k <= NSTAGE - 1; k++)
        begin
            if (en[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---------------- stages 1-4: camera space ----------------
    dpb_pkg::axis_en_t          axis_en;
    logic signed [CAM_W-1:0]    cam_x;
    logic signed [CAM_W-1:0]    cam_y;

    assign axis_en = '{s1: en[1], s2: en[2], s3: en[3], s4: en[4]};

    dpb_axis #(
        .COORD_BITS (COORD_BITS)
    ) u_axis_x (
        .clk       (clk),
        .en        (axis_en),
        .coord     (pixel.column),
        .center    (cx_reg),
        .depth     (pixel.depth),
        .inv_focal (inv_fx_reg),
        .cam       (cam_x)
    );

    dpb_axis #(
        .COORD_BITS (COORD_BITS)
    ) u_axis_y (
        .clk       (clk),
        .en        (axis_en),
        .coord     (pixel.row),
        .center    (cy_reg),
        .depth     (pixel.depth),
        .inv_focal (inv_fy_reg),
        .cam       (cam_y)
    );

    // cam_z = depth * 16, kept non-negative
    logic signed [dpb_pkg::CAMZ_W-1:0] cam_z;

    assign cam_z = $signed({1'b0, side_reg[4].depth, 4'b0000});

    // ---------------- stage 5: transform products ----------------
    logic signed [PXY_W-1:0]        px_reg [4];
    logic signed [PXY_W-1:0]        py_reg [4];
    logic signed [dpb_pkg::PZ_W-1:0] pz_reg [4];

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            for (int r = 0; r < 4; r++)
            begin
                px_reg[r] <= coef[r][0] * cam_x;
                py_reg[r] <= coef[r][1] * cam_y;
                pz_reg[r] <= coef[r][2] * cam_z;
            end
        end
    end

    // ---------------- stage 6: row sums ----------------
    // The cam_w term is 1.0, so its product is the coefficient shifted up
    logic signed [ACC_W-1:0] acc_next [4];
    logic signed [ACC_W-1:0] acc_reg  [4];

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            acc_next[r] = ACC_W'(px_reg[r]) + ACC_W'(py_reg[r]) + ACC_W'(pz_reg[r])
                        + (ACC_W'(coef[r][3]) <<< dpb_pkg::ONE_SHIFT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            for (int r = 0; r < 4; r++)
            begin
                acc_reg[r] <= acc_next[r];
            end
        end
    end

    // ---------------- stage 7: round, saturate, output register ----------------
    localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'({1'b0, {(dpb_pkg::WORLD_W-1){1'b1}}});
    localparam logic signed [SH_W-1:0] SAT_MIN = -SH_W'({1'b0, {(dpb_pkg::WORLD_W-1){1'b1}}})
                                               - SH_W'(1);

    logic signed [RND_W-1:0]            rnd   [4];
    logic signed [SH_W-1:0]             sh    [4];
    logic signed [dpb_pkg::WORLD_W-1:0] wnext [4];
    logic signed [dpb_pkg::WORLD_W-1:0] world_reg [4];
    logic [dpb_pkg::COLOUR_W-1:0]       colour_reg;
    logic                               pvalid_reg;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            rnd[r] = RND_W'(acc_reg[r]) + (RND_W'(1) <<< (dpb_pkg::MAT_SHIFT - 1));
            sh[r]  = rnd[r][RND_W-1:dpb_pkg::MAT_SHIFT];
            if (sh[r] > SAT_MAX)
            begin
                wnext[r] = SAT_MAX[dpb_pkg::WORLD_W-1:0];
            end
            else if (sh[r] < SAT_MIN)
            begin
                wnext[r] = SAT_MIN[dpb_pkg::WORLD_W-1:0];
            end
            else
            begin
                wnext[r] = sh[r][dpb_pkg::WORLD_W-1:0];
            end
        end
    end

    // Zero the whole point for an invalid depth sample
    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            for (int r = 0; r < 4; r++)
            begin
                world_reg[r] <= side_reg[6].flag ? wnext[r] : '0;
            end
            colour_reg <= side_reg[6].flag ? side_reg[6].colour : '0;
            pvalid_reg <= side_reg[6].flag;
        end
    end

    assign point.valid        = v_reg[NSTAGE];
    assign point.world_x      = world_reg[0];
    assign point.world_y      = world_reg[1];
    assign point.world_z      = world_reg[2];
    assign point.world_w      = world_reg[3];
    assign point.point_colour = colour_reg;
    assign point.point_valid  = pvalid_reg;

endmodule

@@ tb/sv/backprojection_check.sv @@
// Scoreboard for depth_pixel_backprojection: mirrors the register file from the write
// channel, predicts one world point per accepted pixel and compares every output transaction.
// Depends on dpb_pkg and the channel interfaces in dpb_if.sv.
`timescale 1ns / 1ps

module backprojection_check #(
    parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    dpb_pixel_if pixel,
    dpb_point_if point,
    dpb_cfg_if   cfg,
    output int   mismatches,
    output int   outstanding
);

    typedef struct packed {
        logic [3:0][dpb_pkg::WORLD_W-1:0] coord;     // x, y, z, w from index 0 up
        logic [dpb_pkg::COLOUR_W-1:0]     colour;
        logic                             valid;
    } world_point_t;

    logic [dpb_pkg::FOCAL_W-1:0]  inv_fx;
    logic [dpb_pkg::FOCAL_W-1:0]  inv_fy;
    logic [dpb_pkg::CENTER_W-1:0] cx;
    logic [dpb_pkg::CENTER_W-1:0] cy;
    logic [dpb_pkg::ROW_W-1:0]    xform [4];

    world_point_t pending_points [$];

    // floor((v + half) / 2^s)
    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [dpb_pkg::WORLD_W-1:0] saturate_q16(input longint v);
        if (v > 64'sd2147483647)
            return {1'b0, {(dpb_pkg::WORLD_W - 1){1'b1}}};
        if (v < -64'sd2147483648)
            return {1'b1, {(dpb_pkg::WORLD_W - 1){1'b0}}};
        return v[dpb_pkg::WORLD_W-1:0];
    endfunction

    function automatic world_point_t backproject(
        input logic [dpb_pkg::DEPTH_W-1:0]  depth,
        input logic                         depth_ok,
        input logic [COORD_BITS-1:0]        column,
        input logic [COORD_BITS-1:0]        row,
        input logic [dpb_pkg::COLOUR_W-1:0] rgbx
    );
        longint       cam [4];
        longint       acc;
        world_point_t pt;
        pt = '0;
        if (depth_ok)
        begin
            cam[0] = round_half_up((longint'(column) * 16 - longint'(cx)) * longint'(depth)
                                   * longint'(inv_fx), dpb_pkg::CAM_SHIFT);
            cam[1] = round_half_up((longint'(row) * 16 - longint'(cy)) * longint'(depth)
                                   * longint'(inv_fy), dpb_pkg::CAM_SHIFT);
            cam[2] = longint'(depth) * 16;
            cam[3] = longint'(1) <<< dpb_pkg::ONE_SHIFT;
            for (int r = 0; r < 4; r++)
            begin
                acc = 0;
                for (int c = 0; c < 4; c++)
                    acc += longint'($signed(xform[r][dpb_pkg::COEF_W*c +: dpb_pkg::COEF_W]))
                           * cam[c];
                pt.coord[r] = saturate_q16(round_half_up(acc, dpb_pkg::MAT_SHIFT));
            end
            pt.colour = rgbx;
            pt.valid  = 1'b1;
        end
        return pt;
    endfunction

    task automatic compare_field(input string name, input logic [dpb_pkg::WORLD_W-1:0] want,
                                 input logic [dpb_pkg::WORLD_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        world_point_t want;
        world_point_t got;
        if (!rst_n)
        begin
            inv_fx      <= dpb_pkg::INV_FX_RST;
            inv_fy      <= dpb_pkg::INV_FY_RST;
            cx          <= dpb_pkg::CX_RST;
            cy          <= dpb_pkg::CY_RST;
            xform[0]    <= dpb_pkg::ROW0_RST;
            xform[1]    <= dpb_pkg::ROW1_RST;
            xform[2]    <= dpb_pkg::ROW2_RST;
            xform[3]    <= dpb_pkg::ROW3_RST;
            pending_points.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    dpb_pkg::REG_INV_FX: inv_fx   <= cfg.data[dpb_pkg::FOCAL_W-1:0];
                    dpb_pkg::REG_INV_FY: inv_fy   <= cfg.data[dpb_pkg::FOCAL_W-1:0];
                    dpb_pkg::REG_CX:     cx       <= cfg.data[dpb_pkg::CENTER_W-1:0];
                    dpb_pkg::REG_CY:     cy       <= cfg.data[dpb_pkg::CENTER_W-1:0];
                    dpb_pkg::REG_ROW0:   xform[0] <= cfg.data[dpb_pkg::ROW_W-1:0];
                    dpb_pkg::REG_ROW1:   xform[1] <= cfg.data[dpb_pkg::ROW_W-1:0];
                    dpb_pkg::REG_ROW2:   xform[2] <= cfg.data[dpb_pkg::ROW_W-1:0];
                    dpb_pkg::REG_ROW3:   xform[3] <= cfg.data[dpb_pkg::ROW_W-1:0];
                    default:             ;
                endcase
            end
            if (point.valid && point.ready)
            begin
                got.coord[0] = point.world_x;
                got.coord[1] = point.world_y;
                got.coord[2] = point.world_z;
                got.coord[3] = point.world_w;
                got.colour   = point.point_colour;
                got.valid    = point.point_valid;
                if (pending_points.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: point with nothing expected, actual %h %h %h %h %h %b",
                             $time, got.coord[0], got.coord[1], got.coord[2],
                             got.coord[3], got.colour, got.valid);
                end
                else
                begin
                    want = pending_points.pop_front();
                    compare_field("world_x", want.coord[0], got.coord[0]);
                    compare_field("world_y", want.coord[1], got.coord[1]);
                    compare_field("world_z", want.coord[2], got.coord[2]);
                    compare_field("world_w", want.coord[3], got.coord[3]);
                    compare_field("point_colour", want.colour, got.colour);
                    compare_field("point_valid", dpb_pkg::WORLD_W'(want.valid),
                                  dpb_pkg::WORLD_W'(got.valid));
                end
            end
            if (pixel.valid && pixel.ready)
                pending_points.push_back(backproject(pixel.depth, pixel.depth_valid,
                                                     pixel.column, pixel.row, pixel.rgbx));
            outstanding <= pending_points.size();
        end
    end

endmodule

@@ tb/sv/tb.sv @@
// Top of the depth_pixel_backprojection testbench: clock, reset, pixel and register
// stimulus, output back-pressure and the verdict. Depends on dpb_pkg, dpb_if.sv,
// backprojection_check and the block itself.
`timescale 1ns / 1ps

module tb;
    import dpb_pkg::*;

    localparam int COORD_BITS     = COORD_BITS_DEF;
    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
    localparam int RESET_CYCLES   = 5;
    localparam int PIPE_LATENCY   = 7;      // pixel taken to point presented
    localparam int ITEMS_PER_SET  = 78;     // random pixels per register setting
    localparam int SQUEEZE_CYCLES = 80;     // long output hold-off, well past the pipe depth
    localparam int STALL_LIMIT    = 2000;   // cycles without any transaction
    localparam int NUM_REGS       = REG_ROW3 + 1;

    typedef struct packed {
        logic [DEPTH_W-1:0]    depth;
        logic                  depth_valid;
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        logic [COLOUR_W-1:0]   rgbx;
    } pixel_t;

    typedef enum int {
        SET_TYPICAL,    // camera-like intrinsics and a near-rigid transform
        SET_HIGH,       // focal terms and center column at top, center row zero, coefficients at both signed limits
        SET_LOW,        // zero focal terms, zero center column, top center row
        SET_RANDOM      // every register bit random
    } settings_style_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int mismatches;
    int outstanding;
    int burst_left    = 0;
    int squeeze_asked = 0;
    int squeeze_done  = 0;

    logic [CFG_DAT_W-1:0] reg_image [NUM_REGS];
    settings_style_t      plan [6] = '{SET_TYPICAL, SET_HIGH, SET_RANDOM,
                                       SET_LOW, SET_TYPICAL, SET_RANDOM};

    dpb_pixel_if #(.COORD_BITS(COORD_BITS)) pixel_bus ();
    dpb_point_if                            point_bus ();
    dpb_cfg_if                              cfg_bus ();

    depth_pixel_backprojection #(.COORD_BITS(COORD_BITS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel_bus),
        .point (point_bus),
        .cfg   (cfg_bus)
    );

    backprojection_check #(.COORD_BITS(COORD_BITS)) proj_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pixel_bus),
        .point       (point_bus),
        .cfg         (cfg_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Pixel construction
    // ------------------------------------------------------------------
    function automatic pixel_t make_pixel(input logic [DEPTH_W-1:0] depth, input logic ok,
                                          input int column, input int row,
                                          input logic [COLOUR_W-1:0] rgbx);
        pixel_t p;
        p.depth       = depth;
        p.depth_valid = ok;
        p.column      = column[COORD_BITS-1:0];
        p.row         = row[COORD_BITS-1:0];
        p.rgbx        = rgbx;
        return p;
    endfunction

    // Mix full-range depths with short-range ones (where the transform stays in range)
    // and the exact limits; keep most samples valid, as a sensor would.
    function automatic pixel_t random_pixel();
        pixel_t p;
        int     pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            p.depth = DEPTH_W'($urandom);
        else if (pick < 8)
            p.depth = DEPTH_W'($urandom_range(0, 16'h3FFF));
        else begin
            case ($urandom_range(0, 3))
                0:       p.depth = '0;
                1:       p.depth = '1;
                2:       p.depth = {1'b1, {(DEPTH_W - 1){1'b0}}};
                default: p.depth = DEPTH_W'(1);
            endcase
        end
        p.depth_valid = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 2) == 0) begin
            // inside a VGA-sized frame around the default principal point
            p.column = COORD_BITS'($urandom_range(0, 639));
            p.row    = COORD_BITS'($urandom_range(0, 479));
        end
        else begin
            p.column = COORD_BITS'($urandom_range(0, COORD_MAX));
            p.row    = COORD_BITS'($urandom_range(0, COORD_MAX));
        end
        p.rgbx = $urandom;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Pixel sender: bursts of random length, random gaps between them.
    // Hold valid high across back-to-back transactions; lower it only for a gap.
    // ------------------------------------------------------------------
    task automatic offer_pixel(input pixel_t p);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20)
                                                     : $urandom_range(0, 3);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 16);
            if (gap != 0) begin
                pixel_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pixel_bus.valid       <= 1'b1;
        pixel_bus.depth       <= p.depth;
        pixel_bus.depth_valid <= p.depth_valid;
        pixel_bus.column      <= p.column;
        pixel_bus.row         <= p.row;
        pixel_bus.rgbx        <= p.rgbx;
        do @(posedge clk); while (!pixel_bus.ready);
    endtask

    // Drop valid, let every expected point come out, then allow the pipe to go quiet
    // before anything touches the registers.
    task automatic settle();
        pixel_bus.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Register writes
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= data;
        do @(posedge clk); while (!cfg_bus.ready);
    endtask

    function automatic logic [ROW_W-1:0] pack_row(input logic [COEF_W-1:0] c0, c1, c2, c3);
        return {c3, c2, c1, c0};
    endfunction

    function automatic logic [COEF_W-1:0] small_coef(input int span);
        return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Fill the register image; narrow registers get random upper bits, which the
    // block must drop.
    task automatic choose_settings(input settings_style_t style);
        logic [COEF_W-1:0] top_coef;
        logic [COEF_W-1:0] bottom_coef;
        top_coef    = {1'b0, {(COEF_W - 1){1'b1}}};
        bottom_coef = {1'b1, {(COEF_W - 1){1'b0}}};
        for (int k = 0; k < NUM_REGS; k++)
            reg_image[k] = {$urandom, $urandom};
        case (style)
            SET_TYPICAL: begin
                reg_image[REG_INV_FX][FOCAL_W-1:0]  = FOCAL_W'($urandom_range(30000, 34000));
                reg_image[REG_INV_FY][FOCAL_W-1:0]  = FOCAL_W'($urandom_range(30000, 34000));
                reg_image[REG_CX][CENTER_W-1:0]     = CX_RST - CENTER_W'($urandom_range(0, 32));
                reg_image[REG_CY][CENTER_W-1:0]     = CY_RST - CENTER_W'($urandom_range(0, 32));
                reg_image[REG_ROW0] = pack_row(16'h1000 - small_coef(128) - 16'd128,
                                               small_coef(1024), small_coef(1024),
                                               small_coef(16'h4000));
                reg_image[REG_ROW1] = pack_row(small_coef(1024),
                                               16'h1000 - small_coef(128) - 16'd128,
                                               small_coef(1024), small_coef(16'h4000));
                reg_image[REG_ROW2] = pack_row(small_coef(1024), small_coef(1024),
                                               16'h1000 - small_coef(128) - 16'd128,
                                               small_coef(16'h4000));
                reg_image[REG_ROW3] = ROW3_RST;
            end
            SET_HIGH: begin
                reg_image[REG_INV_FX][FOCAL_W-1:0]  = '1;
                reg_image[REG_INV_FY][FOCAL_W-1:0]  = '1;
                reg_image[REG_CX][CENTER_W-1:0]     = '1;
                reg_image[REG_CY][CENTER_W-1:0]     = '0;
                reg_image[REG_ROW0] = pack_row(top_coef, top_coef, top_coef, top_coef);
                reg_image[REG_ROW1] = pack_row(bottom_coef, bottom_coef, bottom_coef, bottom_coef);
                reg_image[REG_ROW2] = pack_row(top_coef, bottom_coef, top_coef, bottom_coef);
                reg_image[REG_ROW3] = pack_row(bottom_coef, top_coef, bottom_coef, top_coef);
            end
            SET_LOW: begin
                reg_image[REG_INV_FX][FOCAL_W-1:0]  = '0;
                reg_image[REG_INV_FY][FOCAL_W-1:0]  = '0;
                reg_image[REG_CX][CENTER_W-1:0]     = '0;
                reg_image[REG_CY][CENTER_W-1:0]     = '1;
                reg_image[REG_ROW0] = '0;
                reg_image[REG_ROW1] = pack_row(bottom_coef, bottom_coef, bottom_coef, bottom_coef);
                reg_image[REG_ROW2] = pack_row(top_coef, top_coef, top_coef, top_coef);
                reg_image[REG_ROW3] = '0;
            end
            default: ;  // SET_RANDOM keeps the random image as drawn
        endcase
    endtask

    // Write every register in index order, then one write to an unused index,
    // which the block must ignore.
    task automatic load_config();
        cfg_reg_t r;
        r = r.first();
        repeat (NUM_REGS) begin
            write_reg(r, reg_image[r]);
            r = r.next();
        end
        write_reg(CFG_IDX_W'(NUM_REGS + $urandom_range(0, 7)), {$urandom, $urandom});
        cfg_bus.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Point receiver: random stall patterns, plus a long hold-off on request so
    // the pipe fills and pixel.ready drops while the sender keeps offering.
    // ------------------------------------------------------------------
    initial begin : receiver
        int mode;
        int mode_left;
        int tick;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        point_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (squeeze_done < squeeze_asked) begin
                squeeze_done++;
                point_bus.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
            end
            else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                tick++;
                case (mode)
                    0:       point_bus.ready <= 1'b1;                       // no stalls
                    1:       point_bus.ready <= ($urandom_range(0, 3) != 0);
                    2:       point_bus.ready <= ($urandom_range(0, 2) == 0);
                    default: point_bus.ready <= ((tick % 5) < 3);           // fixed cadence
                endcase
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no transaction moves for too long.
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((pixel_bus.valid && pixel_bus.ready) || (point_bus.valid && point_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("depth_pixel_backprojection test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int ctr_col;
        int ctr_row;
        ctr_col = CX_RST >> 4;
        ctr_row = CY_RST >> 4;

        pixel_bus.valid       <= 1'b0;
        pixel_bus.depth       <= '0;
        pixel_bus.depth_valid <= 1'b0;
        pixel_bus.column      <= '0;
        pixel_bus.row         <= '0;
        pixel_bus.rgbx        <= '0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= '0;
        cfg_bus.data          <= '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: identity transform, default intrinsics.
        // Cover zero and full depth, the image corners, the principal point,
        // the smallest offsets (rounding), invalid samples and alternating bits.
        offer_pixel(make_pixel('0, 1'b1, 0, 0, '0));
        offer_pixel(make_pixel('1, 1'b1, COORD_MAX, COORD_MAX, '1));
        offer_pixel(make_pixel('1, 1'b1, 0, 0, 32'hA5A5_A5A5));
        offer_pixel(make_pixel('1, 1'b1, COORD_MAX, 0, 32'h5A5A_5A5A));
        offer_pixel(make_pixel('1, 1'b1, 0, COORD_MAX, 32'h0F0F_F0F0));
        offer_pixel(make_pixel(16'h1000, 1'b1, ctr_col, ctr_row, 32'h0102_0304));
        offer_pixel(make_pixel(16'h0001, 1'b1, ctr_col + 1, ctr_row + 1, 32'h8000_0001));
        offer_pixel(make_pixel(16'h0001, 1'b1, ctr_col - 1, ctr_row - 1, 32'h7FFF_FFFE));
        // invalid depth: every output field must be zero whatever the input holds
        offer_pixel(make_pixel('1, 1'b0, COORD_MAX, COORD_MAX, '1));
        offer_pixel(make_pixel('0, 1'b0, 0, 0, '0));
        offer_pixel(make_pixel(16'h1234, 1'b0, ctr_col, ctr_row, 32'hDEAD_BEEF));
        offer_pixel(make_pixel(16'hAAAA, 1'b1, 12'hAAA, 12'h555, 32'hAAAA_AAAA));
        offer_pixel(make_pixel(16'h5555, 1'b1, 12'h555, 12'hAAA, 32'h5555_5555));
        offer_pixel(make_pixel(16'h8000, 1'b1, 2 * ctr_col, 2 * ctr_row, 32'h1234_5678));
        repeat (ITEMS_PER_SET) offer_pixel(random_pixel());
        settle();

        // Walk through the register settings; drain fully before each reload.
        foreach (plan[p]) begin
            choose_settings(plan[p]);
            load_config();
            if (plan[p] == SET_HIGH || plan[p] == SET_LOW) begin
                // corners at full depth drive the sums to both saturation limits
                for (int k = 0; k < 4; k++)
                    offer_pixel(make_pixel('1, 1'b1, k[0] ? COORD_MAX : 0,
                                           k[1] ? COORD_MAX : 0, $urandom));
            end
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                // hold the output off mid-phase twice in the run to back the pipe up
                if (n == 20 && (p == 1 || p == 4))
                    squeeze_asked++;
                offer_pixel(random_pixel());
            end
            settle();
        end

        if (mismatches == 0)
            $display("depth_pixel_backprojection test passed");
        else
            $display("depth_pixel_backprojection test failed");
        $finish;
    end

endmodule
